[sv/zwe_pkg.sv]
// Shared types and constants for the Z-character word encoder.
`default_nettype none

package zwe_pkg;

    typedef enum logic [1:0] {
        MODE_CHAR = 2'd0,
        MODE_END  = 2'd1,
        MODE_MAP  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [6:0] map_position;
    } req_item_t;

    typedef struct packed {
        logic [15:0] word_first;
        logic [15:0] word_second;
        logic [15:0] word_third;
    } res_item_t;

    // one encode step as seen by the encoder, i.e. the request leaving stage 1
    typedef struct packed {
        logic       fire;
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [6:0] map_position;
        logic [6:0] rd_position;
        logic [3:0] version;
    } step_t;

    typedef logic [11:0][4:0] zbuf_t;

    localparam logic [0:0]  REG_VERSION   = 1'b0;
    localparam logic [3:0]  VERSION_RESET = 4'd5;
    localparam logic [6:0]  POS_ABSENT    = 7'd78;
    localparam logic [6:0]  ALPHA_SPAN    = 7'd26;
    localparam logic [4:0]  ZC_PAD        = 5'd5;
    localparam logic [4:0]  ZC_ESCAPE     = 5'd6;
    localparam logic [15:0] END_BIT       = 16'h8000;

endpackage

`default_nettype wire

[sv/zwe_map_mem.sv]
// Single-port alphabet map RAM, 256 x 7, registered read.
`default_nettype none

module zwe_map_mem (
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic       we,
    input  wire logic [7:0] addr,
    input  wire logic [6:0] wdata,
    output logic [6:0]      rdata
);
    logic [6:0] mem [256];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[sv/zwe_encode.sv]
// Per-word encode state: held character, alphabet, Z-character buffer.
`default_nettype none

module zwe_encode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire zwe_pkg::step_t step,
    output zwe_pkg::zbuf_t     zbuf_after,
    output logic [3:0]         count_after
);
    import zwe_pkg::*;

    logic [7:0] held_char_reg, held_char_next;
    logic [6:0] held_pos_reg, held_pos_next;
    logic       held_valid_reg, held_valid_next;
    logic [1:0] cur_alph_reg, cur_alph_next;
    zbuf_t      zbuf_reg, zbuf_next;
    logic [3:0] count_reg, count_next;

    logic [1:0] alph, next_alph, delta;
    logic       v12, absent, lock, do_encode;
    logic [3:0] limit;
    logic [6:0] zc_full;
    logic [4:0] zs [4];
    logic [2:0] n;

    function automatic logic [1:0] alph_of(input logic [6:0] pos);
        if (pos >= POS_ABSENT)
            return 2'd2;
        else if (pos >= (ALPHA_SPAN + ALPHA_SPAN))
            return 2'd2;
        else if (pos >= ALPHA_SPAN)
            return 2'd1;
        else
            return 2'd0;
    endfunction

    always_comb
    begin
        v12       = (step.version <= 4'd2);
        limit     = (step.version <= 4'd3) ? 4'd6 : 4'd9;
        absent    = (held_pos_reg >= POS_ABSENT);
        alph      = alph_of(held_pos_reg);
        next_alph = alph_of(step.rd_position);
        do_encode = held_valid_reg && (count_reg < limit) &&
                    (step.mode == MODE_CHAR || step.mode == MODE_END);
        lock      = v12 && (alph != cur_alph_reg) && (step.mode == MODE_CHAR) &&
                    (next_alph == alph);
        // distance forward around the three alphabets
        case ({alph, cur_alph_reg})
            {2'd1, 2'd0}, {2'd2, 2'd1}, {2'd0, 2'd2}: delta = 2'd1;
            {2'd2, 2'd0}, {2'd0, 2'd1}, {2'd1, 2'd2}: delta = 2'd2;
            default:                                  delta = 2'd0;
        endcase
        zc_full = held_pos_reg - 7'(alph) * ALPHA_SPAN + 7'd6;

        n = 3'd0;
        for (int j = 0; j < 4; j++)
            zs[j] = ZC_PAD;
        if (do_encode)
        begin
            if (delta != 2'd0)
            begin
                zs[n[1:0]] = (v12 ? 5'd1 : 5'd3) + 5'(delta) + (lock ? 5'd2 : 5'd0);
                n = n + 3'd1;
            end
            if (!absent)
            begin
                zs[n[1:0]] = zc_full[4:0];
                n = n + 3'd1;
            end
            else
            begin
                // escape, then the code's top three and low five bits
                zs[n[1:0]] = ZC_ESCAPE;
                zs[n[1:0] + 2'd1] = {2'b00, held_char_reg[7:5]};
                zs[n[1:0] + 2'd2] = held_char_reg[4:0];
                n = n + 3'd3;
            end
        end

        zbuf_after = zbuf_reg;
        for (int i = 0; i < 12; i++)
            for (int j = 0; j < 4; j++)
                if ((3'(j) < n) && (count_reg + 4'(j) == 4'(i)))
                    zbuf_after[i] = zs[j];
        count_after = count_reg + {1'b0, n};
    end

    always_comb
    begin
        held_char_next  = held_char_reg;
        held_pos_next   = held_pos_reg;
        held_valid_next = held_valid_reg;
        cur_alph_next   = cur_alph_reg;
        zbuf_next       = zbuf_reg;
        count_next      = count_reg;
        if (step.fire)
        begin
            case (mode_t'(step.mode))
                MODE_CHAR:
                begin
                    zbuf_next       = zbuf_after;
                    count_next      = count_after;
                    held_char_next  = step.char_code;
                    held_pos_next   = step.rd_position;
                    held_valid_next = 1'b1;
                    if (do_encode && lock)
                        cur_alph_next = alph;
                end
                MODE_END:
                begin
                    held_char_next  = 8'd0;
                    held_valid_next = 1'b0;
                    cur_alph_next   = 2'd0;
                    count_next      = 4'd0;
                end
                MODE_MAP:
                begin
                    // keep the held character's position in step with the map
                    if (step.char_code == held_char_reg)
                        held_pos_next = step.map_position;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            cur_alph_reg   <= 2'd0;
            count_reg      <= 4'd0;
        end
        else
        begin
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            cur_alph_reg   <= cur_alph_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_pos_reg <= held_pos_next;
        zbuf_reg     <= zbuf_next;
    end

endmodule

`default_nettype wire

[sv/zwe_pack.sv]
// Pads the Z-character buffer with fives and packs it into three words.
`default_nettype none

module zwe_pack (
    input  wire zwe_pkg::zbuf_t  zbuf,
    input  wire logic [3:0]      count,
    input  wire logic [3:0]      version,
    output zwe_pkg::res_item_t   words
);
    import zwe_pkg::*;

    logic [4:0] slot [9];
    logic       short_word;

    always_comb
    begin
        short_word = (version <= 4'd3);
        for (int i = 0; i < 9; i++)
            slot[i] = (4'(i) < count) ? zbuf[i] : ZC_PAD;
        words.word_first  = {1'b0, slot[0], slot[1], slot[2]};
        words.word_second = {1'b0, slot[3], slot[4], slot[5]};
        words.word_third  = short_word ? 16'd0 : {1'b0, slot[6], slot[7], slot[8]};
        if (short_word)
            words.word_second = words.word_second | END_BIT;
        else
            words.word_third = words.word_third | END_BIT;
    end

endmodule

`default_nettype wire

[sv/zchar_word_encoder_top.sv]
// Top level of the Z-character word encoder.
// An end-of-word request passes through stage 1 into the result register, where its result is valid.
// Throughput: one request per cycle while stage 1 does not stall; a map or character request makes one map RAM access.
// A full result register stalls only end-of-word requests in stage 1.
// Reset clears the word state and sets the version register to 5.
// Map RAM contents are undefined after reset until written.
`default_nettype none

module zchar_word_encoder_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire zwe_pkg::req_item_t req_data,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output zwe_pkg::res_item_t      res_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import zwe_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    req_item_t  s1_item_reg;
    logic       res_valid_reg, res_valid_next;
    res_item_t  res_data_reg;
    logic [3:0] version_reg, version_next;

    logic       accept, s1_go, res_free, res_load;
    logic [6:0] map_rdata;
    step_t      step;
    zbuf_t      zbuf_after;
    logic [3:0] count_after;
    res_item_t  packed_words;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERSION) ? {28'd0, version_reg} : 32'd0;

    assign res_free  = !res_valid_reg || res_ready;
    assign s1_go     = s1_valid_reg && ((s1_item_reg.mode != MODE_END) || res_free);
    assign req_ready = !s1_valid_reg || s1_go;
    assign accept    = req_valid && req_ready;
    assign res_load  = s1_go && (s1_item_reg.mode == MODE_END);

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    zwe_map_mem u_map (
        .clk   (clk),
        .en    (accept && (req_data.mode == MODE_MAP || req_data.mode == MODE_CHAR)),
        .we    (req_data.mode == MODE_MAP),
        .addr  (req_data.char_code),
        .wdata (req_data.map_position),
        .rdata (map_rdata)
    );

    always_comb
    begin
        step.fire         = s1_go;
        step.mode         = s1_item_reg.mode;
        step.char_code    = s1_item_reg.char_code;
        step.map_position = s1_item_reg.map_position;
        step.rd_position  = map_rdata;
        step.version      = version_reg;
    end

    zwe_encode u_encode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .zbuf_after  (zbuf_after),
        .count_after (count_after)
    );

    zwe_pack u_pack (
        .zbuf    (zbuf_after),
        .count   (count_after),
        .version (version_reg),
        .words   (packed_words)
    );

    always_comb
    begin
        version_next = version_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_VERSION))
            version_next = pwdata[3:0];

        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg   <= VERSION_RESET;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            version_reg   <= version_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= req_data;
        if (res_load)
            res_data_reg <= packed_words;
    end

endmodule

`default_nettype wire

[sv/zwe_checker.sv]
// Port-level checks on the encoder's result channel, bound to the top level.
`default_nettype none

module zwe_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    input  wire logic               res_ready,
    input  wire zwe_pkg::res_item_t res_data
);
    import zwe_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_first_top: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_data.word_first[15])
        else $error("first word has end bit");

    // exactly one of the second and third words carries the end bit
    a_one_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.word_second[15] != res_data.word_third[15]))
        else $error("end bit missing or doubled");

    a_third_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.word_third == 16'd0) || res_data.word_third[15])
        else $error("third word neither zero nor terminated");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.word_second[15] |-> res_data.word_third == 16'd0)
        else $error("third word not zero for short encoding");

endmodule

bind zchar_word_encoder_top zwe_checker u_zwe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire
